// File: rtl/bitmap_slot_allocator_assert.svh
// Assertion macros for the checker file of the slot allocator.
// Both sample on i_clk and are switched off while i_rst_n is low.
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BSA_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Consequent holds in the cycle after the antecedent.
`define BSA_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// File: rtl/bsa_pkg.sv
package bsa_pkg;

    // Fixed field widths.
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 16;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;

    // Slot geometry: 16-byte slots, map kept as 64-bit words.
    localparam int SLOT_BYTES = 16;
    localparam int SLOT_SHIFT = 4;
    localparam int MAP_WORD_W = 64;
    localparam int WORD_SHIFT = 6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] RES_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] RES_BAD_SIZE  = 3'd1;
    localparam logic [STATUS_W-1:0] RES_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] RES_NULL      = 3'd3;
    localparam logic [STATUS_W-1:0] RES_BAD_ADDR  = 3'd4;
    localparam logic [STATUS_W-1:0] RES_NOT_ALLOC = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_SLOT_LIMIT   = 1'b0;
    localparam logic CFG_BASE_ADDRESS = 1'b1;

    // Reset value of the slot limit.
    localparam logic [COUNT_W-1:0] SLOT_LIMIT_RESET = 11'd1024;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                clr_wr;    // write zero to the clear-pass word
        logic                capture;   // take in the accepted item
        logic                scan_next; // move the scan to the next map word
        logic                deliver;   // load the output register
        logic [STATUS_W-1:0] status;    // status of the delivered item
        logic                map_set;   // mark the found slot used
        logic                map_clr;   // mark the freed slot clear
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;   // clear pass is on its last word
        logic out_blocked;  // output register holds an item not taken
        logic is_free;      // captured item is a free
        logic size_zero;    // allocate with zero size
        logic count_full;   // live count at or above the limit
        logic null_ptr;     // free carries a null pointer
        logic bad_addr;     // free address fails the range or alignment check
        logic scan_found;   // current map word has a free slot
        logic scan_last;    // current map word is the last one in range
        logic bit_set;      // slot to free is in use
    } t_dp_sts;

endpackage

// File: rtl/bsa_ctrl.sv
module bsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bsa_pkg::t_dp_sts i_sts,
    output logic             o_stall,
    output bsa_pkg::t_dp_cmd o_cmd
);
    import bsa_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FREE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Items are taken only while idle.
    assign o_stall = (r_state != S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_free) begin
                    if (i_sts.null_ptr || i_sts.bad_addr) begin
                        if (!i_sts.out_blocked) begin
                            o_cmd.deliver = 1'b1;
                            o_cmd.status  = i_sts.null_ptr ? RES_NULL : RES_BAD_ADDR;
                            n_state       = S_IDLE;
                        end
                    end else begin
                        n_state = S_FREE;
                    end
                end else begin
                    if (i_sts.size_zero || i_sts.count_full) begin
                        if (!i_sts.out_blocked) begin
                            o_cmd.deliver = 1'b1;
                            o_cmd.status  = i_sts.size_zero ? RES_BAD_SIZE : RES_FULL;
                            n_state       = S_IDLE;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!i_sts.out_blocked) begin
                    if (i_sts.scan_found) begin
                        o_cmd.deliver = 1'b1;
                        o_cmd.status  = RES_OK;
                        o_cmd.map_set = 1'b1;
                        n_state       = S_IDLE;
                    end else if (i_sts.scan_last) begin
                        o_cmd.deliver = 1'b1;
                        o_cmd.status  = RES_FULL;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                    end
                end
            end
            S_FREE: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.deliver = 1'b1;
                    o_cmd.status  = i_sts.bit_set ? RES_OK : RES_NOT_ALLOC;
                    o_cmd.map_clr = i_sts.bit_set;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the map clear pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/bsa_dp.sv
module bsa_dp #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bsa_pkg::t_dp_cmd              i_cmd,
    output bsa_pkg::t_dp_sts              o_sts,
    input  logic                          i_action,
    input  logic [bsa_pkg::SIZE_W-1:0]    i_request_size,
    input  logic                          i_null_pointer,
    input  logic [bsa_pkg::ADDR_W-1:0]    i_free_address,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bsa_pkg::STATUS_W-1:0]  o_status,
    output logic [bsa_pkg::ADDR_W-1:0]    o_slot_address,
    output logic [bsa_pkg::COUNT_W-1:0]   o_live_slots,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [bsa_pkg::ADDR_W-1:0]    i_cfg_data
);
    import bsa_pkg::*;

    localparam int WORDS   = (MAX_SLOTS + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int WW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MAX_LIM = (MAX_SLOTS > 2047) ? 2047 : MAX_SLOTS;

    // Configuration registers.
    logic [COUNT_W-1:0] r_slot_limit;
    logic [ADDR_W-1:0]  r_base;

    // Captured item.
    logic               r_is_free;
    logic               r_size_zero;
    logic               r_null;
    logic               r_below;
    logic [ADDR_W-1:0]  r_off;

    // Map storage and scan state.
    logic [MAP_WORD_W-1:0] mem [WORDS];
    logic [MAP_WORD_W-1:0] r_rd_data;
    logic [WW-1:0]         r_scan_word;
    logic [WW-1:0]         r_clr_idx;
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    n_count;
    logic                  r_out_valid;

    logic [COUNT_W-1:0]    lim;
    logic [COUNT_W-1:0]    lim_m1;
    logic [WW-1:0]         rd_addr;
    logic [WW-1:0]         free_word;
    logic [WORD_SHIFT-1:0] free_bit;
    logic [MAP_WORD_W-1:0] free_bits;
    logic [WORD_SHIFT-1:0] found_idx;
    logic                  scan_last;
    logic                  wr_en;
    logic [WW-1:0]         wr_addr;
    logic [MAP_WORD_W-1:0] wr_data;

    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= SLOT_LIMIT_RESET;
            r_base       <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SLOT_LIMIT:   r_slot_limit <= i_cfg_data[COUNT_W-1:0];
                CFG_BASE_ADDRESS: r_base       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effective limit is clipped to the map size.
    assign lim    = (r_slot_limit > COUNT_W'(MAX_LIM)) ? COUNT_W'(MAX_LIM) : r_slot_limit;
    assign lim_m1 = lim - 1'b1;

    // Item capture; the offset from the base is formed here.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_free   <= i_action;
            r_size_zero <= (i_request_size == '0);
            r_null      <= i_null_pointer;
            r_below     <= (i_free_address < r_base);
            r_off       <= i_free_address - r_base;
        end
    end

    assign free_word = r_off[SLOT_SHIFT+WORD_SHIFT +: WW];
    assign free_bit  = r_off[SLOT_SHIFT +: WORD_SHIFT];

    // Scan word pointer and clear-pass pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_word <= '0;
            r_clr_idx   <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_scan_word <= '0;
            end else if (i_cmd.scan_next) begin
                r_scan_word <= r_scan_word + 1'b1;
            end
            if (i_cmd.clr_wr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // Read address: the free word for a free, else the scan word, or the next one while the scan steps on.
    always_comb begin
        if (r_is_free) begin
            rd_addr = free_word;
        end else if (i_cmd.scan_next) begin
            rd_addr = r_scan_word + 1'b1;
        end else begin
            rd_addr = r_scan_word;
        end
    end

    assign scan_last = (32'(r_scan_word) == 32'(lim_m1 >> WORD_SHIFT));

    // Clear slots in the current word, with slots past the limit masked off.
    always_comb begin
        for (int b = 0; b < MAP_WORD_W; b++) begin
            free_bits[b] = ~r_rd_data[b] &&
                           (!scan_last || (WORD_SHIFT'(b) <= lim_m1[WORD_SHIFT-1:0]));
        end
    end

    // Lowest clear slot in the word.
    always_comb begin
        found_idx = '0;
        for (int b = MAP_WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                found_idx = WORD_SHIFT'(b);
            end
        end
    end

    // Map write port: clear pass, allocate or free.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_scan_word;
        wr_data = r_rd_data;
        if (i_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
            wr_data = '0;
        end else if (i_cmd.map_set) begin
            wr_en   = 1'b1;
            wr_addr = r_scan_word;
            wr_data = r_rd_data | (MAP_WORD_W'(1) << found_idx);
        end else if (i_cmd.map_clr) begin
            wr_en   = 1'b1;
            wr_addr = free_word;
            wr_data = r_rd_data & ~(MAP_WORD_W'(1) << free_bit);
        end
    end

    // Map memory with registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Live count.
    always_comb begin
        n_count = r_count;
        if (i_cmd.map_set) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.map_clr && (r_count != '0)) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.deliver) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.deliver) begin
            o_status       <= i_cmd.status;
            o_live_slots   <= n_count;
            o_slot_address <= i_cmd.map_set ?
                r_base + ADDR_W'({r_scan_word, found_idx, {SLOT_SHIFT{1'b0}}}) : '0;
        end
    end

    assign o_valid = r_out_valid;

    // Status toward the controller.
    always_comb begin
        o_sts             = '0;
        o_sts.clear_last  = (32'(r_clr_idx) == 32'(WORDS - 1));
        o_sts.out_blocked = r_out_valid && i_stall;
        o_sts.is_free     = r_is_free;
        o_sts.size_zero   = r_size_zero;
        o_sts.count_full  = (r_count >= lim);
        o_sts.null_ptr    = r_null;
        o_sts.bad_addr    = r_below || (r_off[SLOT_SHIFT-1:0] != '0) ||
                            (r_off[ADDR_W-1:SLOT_SHIFT] >= (ADDR_W - SLOT_SHIFT)'(lim));
        o_sts.scan_found  = |free_bits;
        o_sts.scan_last   = scan_last;
        o_sts.bit_set     = r_rd_data[free_bit];
    end

endmodule

// File: rtl/bitmap_slot_allocator.sv
// Channel   Direction  Handshake               Payload
// input     in         i_valid / o_stall       i_action, i_request_size, i_null_pointer,
//                                              i_free_address
// result    out        o_valid / i_stall       o_status, o_slot_address, o_live_slots
// config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A rejected request is answered from the decide state, a free from the free state
// after it. An allocate scans the 64-slot map words, one word per cycle while the
// output register is not blocked, up to the first word with a clear slot or the
// last word in range, where it reports full.
// After reset a clear pass zeroes the map, one word per cycle; o_stall stays high
// meanwhile, configuration writes are taken.
// A result waits in the output register while i_stall is high; the next item
// is still accepted and held until the register is free.
module bitmap_slot_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [bsa_pkg::SIZE_W-1:0]    i_request_size,
    input  logic                          i_null_pointer,
    input  logic [bsa_pkg::ADDR_W-1:0]    i_free_address,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bsa_pkg::STATUS_W-1:0]  o_status,
    output logic [bsa_pkg::ADDR_W-1:0]    o_slot_address,
    output logic [bsa_pkg::COUNT_W-1:0]   o_live_slots,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [bsa_pkg::ADDR_W-1:0]    i_cfg_data
);
    import bsa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    bsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // Map, count, configuration and output register.
    bsa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_request_size (i_request_size),
        .i_null_pointer (i_null_pointer),
        .i_free_address (i_free_address),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_slot_address (o_slot_address),
        .o_live_slots   (o_live_slots),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

endmodule

// File: rtl/bsa_checker.sv
`include "bitmap_slot_allocator_assert.svh"

module bsa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [bsa_pkg::STATUS_W-1:0]  o_status,
    input logic [bsa_pkg::ADDR_W-1:0]    o_slot_address,
    input logic [bsa_pkg::COUNT_W-1:0]   o_live_slots
);
    import bsa_pkg::*;

    // A failed request never returns an address.
    `BSA_CHECK(a_addr_zero_on_fail, o_valid && (o_status != RES_OK), o_slot_address == '0)

    // Status codes stay within the defined set.
    `BSA_CHECK(a_status_range, o_valid, o_status <= RES_NOT_ALLOC)

    // A stalled item stays on the output unchanged.
    `BSA_CHECK_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_status) && $stable(o_slot_address) && $stable(o_live_slots))

    // Coming out of reset no item is shown and input is held off for the clear pass.
    `BSA_CHECK(a_reset_quiet, $past(!i_rst_n), !o_valid && o_stall)

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_slot_address (o_slot_address),
    .o_live_slots   (o_live_slots)
);
